// File: design/tfd_pkg.sv
package tfd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 4;
  localparam int unsigned AppIdW  = 16;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned KindW   = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned AddrW   = 3;

  localparam logic [ByteW-1:0] START_BYTE  = 8'h7E;
  localparam logic [PosW-1:0]  POS_SENSOR  = 4'd1;
  localparam logic [PosW-1:0]  POS_TYPE    = 4'd2;
  localparam logic [PosW-1:0]  POS_APP_LO  = 4'd3;
  localparam logic [PosW-1:0]  POS_APP_HI  = 4'd4;
  localparam logic [PosW-1:0]  POS_VAL_B0  = 4'd5;
  localparam logic [PosW-1:0]  POS_VAL_B1  = 4'd6;
  localparam logic [PosW-1:0]  POS_VAL_B2  = 4'd7;
  localparam logic [PosW-1:0]  POS_VAL_B3  = 4'd8;
  localparam logic [PosW-1:0]  POS_CHECK   = 4'd9;

  // register index, taken from paddr[AddrW-1:2]
  localparam logic REG_DROP_BAD = 1'b0;

  // value kind codes
  localparam logic [KindW-1:0] KIND_UNKNOWN   = 4'd0;
  localparam logic [KindW-1:0] KIND_LATLON    = 4'd1;
  localparam logic [KindW-1:0] KIND_GPS_ALT   = 4'd2;
  localparam logic [KindW-1:0] KIND_GPS_SPEED = 4'd3;
  localparam logic [KindW-1:0] KIND_COURSE    = 4'd4;
  localparam logic [KindW-1:0] KIND_CELL_V    = 4'd5;
  localparam logic [KindW-1:0] KIND_RX_BATT   = 4'd6;
  localparam logic [KindW-1:0] KIND_RSSI      = 4'd7;
  localparam logic [KindW-1:0] KIND_VSPEED    = 4'd8;
  localparam logic [KindW-1:0] KIND_BATT_V    = 4'd9;
  localparam logic [KindW-1:0] KIND_CURRENT   = 4'd10;
  localparam logic [KindW-1:0] KIND_ALTITUDE  = 4'd11;
  localparam logic [KindW-1:0] KIND_DIST_HOME = 4'd12;
  localparam logic [KindW-1:0] KIND_DATETIME  = 4'd13;

  // 8-bit add with end-around carry; a second carry cannot occur
  function automatic logic [ByteW-1:0] fold_add(input logic [ByteW-1:0] sum,
                                                input logic [ByteW-1:0] b);
    logic [ByteW:0] t;
    t = {1'b0, sum} + {1'b0, b};
    return t[ByteW-1:0] + {{(ByteW-1){1'b0}}, t[ByteW]};
  endfunction

  function automatic logic [KindW-1:0] kind_of(input logic [AppIdW-1:0] id);
    logic [KindW-1:0] k;
    case (id)
      16'h0800: k = KIND_LATLON;
      16'h0820: k = KIND_GPS_ALT;
      16'h0830: k = KIND_GPS_SPEED;
      16'h0840: k = KIND_COURSE;
      16'h0910: k = KIND_CELL_V;
      16'hF104: k = KIND_RX_BATT;
      16'hF101: k = KIND_RSSI;
      16'h0110: k = KIND_VSPEED;
      16'h0210: k = KIND_BATT_V;
      16'h0200: k = KIND_CURRENT;
      16'h0100: k = KIND_ALTITUDE;
      16'h0420: k = KIND_DIST_HOME;
      16'h0850: k = KIND_DATETIME;
      default:  k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// File: design/telemetry_frame_deframer.sv
// Channel   Dir  Handshake                  Payload
// ------------------------------------------------------------------------------
// in        in   in_valid_i / in_ready_o    rx_byte_i
// out       out  out_valid_o / out_ready_i  node_id_o, frame_type_o, app_id_o,
//                                           payload_value_o, checksum_good_o,
//                                           value_kind_o
// cfg       in   APB (psel..pready)         drop_bad_frames at byte address 0
//
// One byte per cycle while in_ready_o is high: each transfer updates the frame
// state in the same edge; the checksum byte loads the result register, so a
// frame's result appears in the cycle after its last byte.
// in_ready_o drops only when a checksum byte is due and the result register
// still holds an untaken result; all other bytes keep flowing under a stall.
// Reset clears the frame state, the result valid and sets drop_bad_frames.
module telemetry_frame_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // byte input
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tfd_pkg::ByteW-1:0]   rx_byte_i,
  // frame result
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tfd_pkg::ByteW-1:0]   node_id_o,
  output logic [tfd_pkg::ByteW-1:0]   frame_type_o,
  output logic [tfd_pkg::AppIdW-1:0]  app_id_o,
  output logic [tfd_pkg::ValueW-1:0]  payload_value_o,
  output logic                        checksum_good_o,
  output logic [tfd_pkg::KindW-1:0]   value_kind_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tfd_pkg::AddrW-1:0]   paddr,
  input  logic [tfd_pkg::DataW-1:0]   pwdata,
  output logic [tfd_pkg::DataW-1:0]   prdata,
  output logic                        pready
);
  import tfd_pkg::*;

  // configuration register
  logic drop_bad_q;
  logic reg_sel;

  assign reg_sel = (paddr[AddrW-1:2] == REG_DROP_BAD);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(DataW-1){1'b0}}, drop_bad_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_bad_q <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      drop_bad_q <= pwdata[0];
    end
  end

  // frame state
  logic                in_frame_q, in_frame_d;
  logic [PosW-1:0]     pos_q, pos_d;
  logic [ByteW-1:0]    sensor_q, sensor_d;
  logic [ByteW-1:0]    ftype_q, ftype_d;
  logic [AppIdW-1:0]   app_q, app_d;
  logic [ValueW-1:0]   value_q, value_d;
  logic [ByteW-1:0]    sum_q, sum_d;

  // result register
  logic                out_valid_q, out_valid_d;
  logic [ByteW-1:0]    out_sensor_q;
  logic [ByteW-1:0]    out_ftype_q;
  logic [AppIdW-1:0]   out_app_q;
  logic [ValueW-1:0]   out_value_q;
  logic                out_good_q;
  logic [KindW-1:0]    out_kind_q;

  logic                in_xfer;
  logic                is_start;
  logic [PosW-1:0]     pos_next;
  logic                at_check;
  logic                good;
  logic                emit;

  // Hold the input back only when the checksum byte would need the
  // result register while it is still occupied.
  assign in_ready_o = !(out_valid_q && !out_ready_i && in_frame_q &&
                        (pos_q == POS_VAL_B3));
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_start   = (rx_byte_i == START_BYTE);
  assign pos_next   = pos_q + PosW'(1);
  assign at_check   = in_frame_q && !is_start && (pos_next == POS_CHECK);
  assign good       = (ByteW'(8'hFF - sum_q) == rx_byte_i);
  assign emit       = in_xfer && at_check && (good || !drop_bad_q);

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    sensor_d   = sensor_q;
    ftype_d    = ftype_q;
    app_d      = app_q;
    value_d    = value_q;
    sum_d      = sum_q;
    if (in_xfer) begin
      if (is_start) begin
        // start byte always reopens a frame, dropping any partial one
        in_frame_d = 1'b1;
        pos_d      = '0;
        sum_d      = '0;
      end else if (in_frame_q) begin
        pos_d = pos_next;
        if (pos_next >= POS_TYPE && pos_next <= POS_VAL_B3) begin
          sum_d = fold_add(sum_q, rx_byte_i);
        end
        case (pos_next)
          POS_SENSOR: sensor_d = rx_byte_i;
          POS_TYPE:   ftype_d  = rx_byte_i;
          POS_APP_LO: app_d    = {app_q[15:8], rx_byte_i};
          POS_APP_HI: app_d    = {rx_byte_i, app_q[7:0]};
          POS_VAL_B0: value_d  = {value_q[31:8], rx_byte_i};
          POS_VAL_B1: value_d  = {value_q[31:16], rx_byte_i, value_q[7:0]};
          POS_VAL_B2: value_d  = {value_q[31:24], rx_byte_i, value_q[15:0]};
          POS_VAL_B3: value_d  = {rx_byte_i, value_q[23:0]};
          default: ;
        endcase
        if (pos_next == POS_CHECK) begin
          in_frame_d = 1'b0;
          pos_d      = '0;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q  <= 1'b0;
      pos_q       <= '0;
      sensor_q    <= '0;
      ftype_q     <= '0;
      app_q       <= '0;
      value_q     <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_frame_q  <= in_frame_d;
      pos_q       <= pos_d;
      sensor_q    <= sensor_d;
      ftype_q     <= ftype_d;
      app_q       <= app_d;
      value_q     <= value_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, loaded only with a new result
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_sensor_q <= sensor_q;
      out_ftype_q  <= ftype_q;
      out_app_q    <= app_q;
      out_value_q  <= value_q;
      out_good_q   <= good;
      out_kind_q   <= kind_of(app_q);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign node_id_o       = out_sensor_q;
  assign frame_type_o    = out_ftype_q;
  assign app_id_o        = out_app_q;
  assign payload_value_o = out_value_q;
  assign checksum_good_o = out_good_q;
  assign value_kind_o    = out_kind_q;

endmodule

// File: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tfd_pkg::*;

  // ---------------------------------------------------------------------------
  // Addresses and lookup tables
  // ---------------------------------------------------------------------------
  localparam logic [AddrW-1:0] DROP_BAD_ADDR = {REG_DROP_BAD, 2'b00};
  // next register slot: nothing lives there, writes must be dropped
  localparam logic [AddrW-1:0] UNMAPPED_ADDR = {~REG_DROP_BAD, 2'b00};

  localparam int unsigned NUM_KNOWN_IDS = 13;
  // known application ids and the kind each one maps to, same slot order
  localparam logic [NUM_KNOWN_IDS-1:0][AppIdW-1:0] KNOWN_APP_IDS = {
    16'h0800, 16'h0820, 16'h0830, 16'h0840, 16'h0910, 16'hF104, 16'hF101,
    16'h0110, 16'h0210, 16'h0200, 16'h0100, 16'h0420, 16'h0850
  };
  localparam logic [NUM_KNOWN_IDS-1:0][KindW-1:0] KNOWN_KINDS = {
    KIND_LATLON, KIND_GPS_ALT, KIND_GPS_SPEED, KIND_COURSE, KIND_CELL_V,
    KIND_RX_BATT, KIND_RSSI, KIND_VSPEED, KIND_BATT_V, KIND_CURRENT,
    KIND_ALTITUDE, KIND_DIST_HOME, KIND_DATETIME
  };

  localparam int unsigned FRAME_LEN    = 10;   // start byte through checksum byte
  localparam int unsigned HOLD_AT      = 20;   // results taken before the long hold-off
  localparam int unsigned HOLD_CYCLES  = 300;

  typedef struct packed {
    logic [ByteW-1:0]  node_id;
    logic [ByteW-1:0]  frame_type;
    logic [AppIdW-1:0] app_id;
    logic [ValueW-1:0] value;
    logic              good;
    logic [KindW-1:0]  kind;
  } frame_result_t;

  // one byte waiting to be sent, plus the idle cycles the sender inserts after it
  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [2:0]       gap;
  } line_byte_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               in_valid_i      = 1'b0;
  logic               in_ready_o;
  logic [ByteW-1:0]   rx_byte_i       = '0;
  logic               out_valid_o;
  logic               out_ready_i     = 1'b0;
  logic [ByteW-1:0]   node_id_o;
  logic [ByteW-1:0]   frame_type_o;
  logic [AppIdW-1:0]  app_id_o;
  logic [ValueW-1:0]  payload_value_o;
  logic               checksum_good_o;
  logic [KindW-1:0]   value_kind_o;
  logic               psel            = 1'b0;
  logic               penable         = 1'b0;
  logic               pwrite          = 1'b0;
  logic [AddrW-1:0]   paddr           = '0;
  logic [DataW-1:0]   pwdata          = '0;
  logic [DataW-1:0]   prdata;
  logic               pready;

  telemetry_frame_deframer u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor: shadow of the deframer state, updated on every input
  // transfer. Reset values match the DUT reset (drop_bad_frames set).
  // ---------------------------------------------------------------------------
  logic              drop_bad_shadow = 1'b1;
  logic              frame_open      = 1'b0;
  logic [PosW-1:0]   frame_pos       = '0;
  logic [ByteW-1:0]  got_sensor      = '0;
  logic [ByteW-1:0]  got_type        = '0;
  logic [AppIdW-1:0] got_app         = '0;
  logic [ValueW-1:0] got_value       = '0;
  logic [ByteW-1:0]  sum_acc         = '0;

  frame_result_t expected_frames[$];
  line_byte_t    byte_backlog[$];

  int unsigned mismatches    = 0;
  int unsigned results_taken = 0;

  // ones' complement style add: a carry out of bit 7 wraps back into bit 0
  function automatic logic [ByteW-1:0] fold8(input logic [ByteW-1:0] s,
                                             input logic [ByteW-1:0] b);
    logic [ByteW:0] t;
    t = {1'b0, s} + {1'b0, b};
    if (t[ByteW])
      t = t + 1'b1;
    return t[ByteW-1:0];
  endfunction

  function automatic logic [KindW-1:0] kind_for(input logic [AppIdW-1:0] id);
    logic [KindW-1:0] k;
    k = KIND_UNKNOWN;
    for (int i = 0; i < NUM_KNOWN_IDS; i++)
      if (KNOWN_APP_IDS[i] == id)
        k = KNOWN_KINDS[i];
    return k;
  endfunction

  function automatic void take_byte(input logic [ByteW-1:0] b);
    logic [PosW-1:0] pos;
    logic            check_ok;
    frame_result_t   res;
    // start byte wins anywhere, even in the checksum slot
    if (b == START_BYTE) begin
      frame_open = 1'b1;
      frame_pos  = '0;
      sum_acc    = '0;
      return;
    end
    if (!frame_open)
      return;
    pos       = frame_pos + 1'b1;
    frame_pos = pos;
    if (pos >= POS_TYPE && pos <= POS_VAL_B3)
      sum_acc = fold8(sum_acc, b);
    case (pos)
      POS_SENSOR: got_sensor        = b;
      POS_TYPE:   got_type          = b;
      POS_APP_LO: got_app[7:0]      = b;
      POS_APP_HI: got_app[15:8]     = b;
      POS_VAL_B0: got_value[7:0]    = b;
      POS_VAL_B1: got_value[15:8]   = b;
      POS_VAL_B2: got_value[23:16]  = b;
      POS_VAL_B3: got_value[31:24]  = b;
      default: ;
    endcase
    if (pos < POS_CHECK)
      return;
    // checksum byte closes the frame
    frame_open = 1'b0;
    frame_pos  = '0;
    check_ok   = ((8'hFF - sum_acc) == b);
    if (!check_ok && drop_bad_shadow)
      return;
    res.node_id    = got_sensor;
    res.frame_type = got_type;
    res.app_id     = got_app;
    res.value      = got_value;
    res.good       = check_ok;
    res.kind       = kind_for(got_app);
    expected_frames.push_back(res);
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
  endfunction

  // ---------------------------------------------------------------------------
  // Byte sender: pops the backlog, holds valid and data until the transfer,
  // then idles for the gap attached to that byte.
  // ---------------------------------------------------------------------------
  logic [2:0] idle_left = '0;

  always @(posedge clk_i) begin : byte_sender
    line_byte_t nxt;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        take_byte(rx_byte_i);
      if (!(in_valid_i && !in_ready_o)) begin
        if (idle_left != 0) begin
          idle_left  <= idle_left - 1'b1;
          in_valid_i <= 1'b0;
        end else if (byte_backlog.size() != 0) begin
          nxt        = byte_backlog.pop_front();
          in_valid_i <= 1'b1;
          rx_byte_i  <= nxt.data;
          idle_left  <= nxt.gap;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off on the result side, counted here. While it runs the sender
  // keeps going, so the result register stays full and the next checksum
  // byte backs up the input.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  always @(posedge clk_i) begin : long_hold
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_taken >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: a random stall, possibly none, after each transfer, with runs of
  // sixteen results taken back to back.
  // ---------------------------------------------------------------------------
  int unsigned stall_left = 0;

  always @(posedge clk_i) begin : result_receiver
    int unsigned stall_n;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        stall_n = results_taken[4] ? 0 : $urandom_range(0, 4);
      else
        stall_n = (stall_left != 0) ? stall_left - 1 : 0;
      stall_left  <= stall_n;
      out_ready_i <= (stall_n == 0) && (hold_left == 0);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: each transfer against the oldest predicted frame
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_checker
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_taken <= results_taken + 1;
      if (expected_frames.size() == 0) begin
        note_mismatch("unexpected result, app_id", '0, 32'(app_id_o));
      end else begin
        want = expected_frames.pop_front();
        if (node_id_o !== want.node_id)
          note_mismatch("node_id", 32'(want.node_id), 32'(node_id_o));
        if (frame_type_o !== want.frame_type)
          note_mismatch("frame_type", 32'(want.frame_type), 32'(frame_type_o));
        if (app_id_o !== want.app_id)
          note_mismatch("app_id", 32'(want.app_id), 32'(app_id_o));
        if (payload_value_o !== want.value)
          note_mismatch("payload_value", want.value, payload_value_o);
        if (checksum_good_o !== want.good)
          note_mismatch("checksum_good", 32'(want.good), 32'(checksum_good_o));
        if (value_kind_o !== want.kind)
          note_mismatch("value_kind", 32'(want.kind), 32'(value_kind_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic [ByteW-1:0] b, input bit calm);
    line_byte_t item;
    item.data = b;
    item.gap  = calm ? 3'd0 : 3'($urandom_range(0, 4));
    byte_backlog.push_back(item);
  endtask

  // builds a frame with a correct checksum, xors 'flip' into the checksum byte
  // and queues the first 'keep' bytes (start byte included)
  task automatic add_frame(input logic [ByteW-1:0] sensor, input logic [ByteW-1:0] ftype,
                           input logic [AppIdW-1:0] app, input logic [ValueW-1:0] value,
                           input logic [ByteW-1:0] flip, input int unsigned keep,
                           input bit calm);
    logic [ByteW-1:0] fb [FRAME_LEN];
    logic [ByteW-1:0] s;
    fb[0] = START_BYTE;
    fb[1] = sensor;
    fb[2] = ftype;
    fb[3] = app[7:0];
    fb[4] = app[15:8];
    fb[5] = value[7:0];
    fb[6] = value[15:8];
    fb[7] = value[23:16];
    fb[8] = value[31:24];
    s = '0;
    for (int i = 2; i <= 8; i++)
      s = fold8(s, fb[i]);
    fb[9] = (8'hFF - s) ^ flip;
    for (int i = 0; i < keep; i++)
      push_byte(fb[i], calm);
  endtask

  // mostly well-formed frames with random content; the rest bad checksums,
  // cut-off frames and line noise. Only frame bytes count against the budget.
  task automatic add_random(input int unsigned budget);
    int unsigned      used;
    int unsigned      n;
    int unsigned      roll;
    int unsigned      keep;
    bit               calm;
    logic [ByteW-1:0] ftype;
    logic [AppIdW-1:0] app;
    logic [ValueW-1:0] value;
    used = 0;
    n    = 0;
    while (used < budget) begin
      calm  = (n % 12) < 3;
      ftype = ($urandom_range(0, 1) != 0) ? 8'h10 : 8'($urandom);
      app   = ($urandom_range(0, 9) < 6) ? KNOWN_APP_IDS[$urandom_range(0, NUM_KNOWN_IDS-1)]
                                         : 16'($urandom);
      case ($urandom_range(0, 9))
        0:       value = '0;
        1:       value = '1;
        default: value = $urandom;
      endcase
      roll = $urandom_range(0, 99);
      if (roll < 62) begin
        add_frame(8'($urandom), ftype, app, value, 8'h00, FRAME_LEN, calm);
        used += FRAME_LEN;
      end else if (roll < 77) begin
        add_frame(8'($urandom), ftype, app, value, 8'($urandom_range(1, 255)), FRAME_LEN,
                  calm);
        used += FRAME_LEN;
      end else if (roll < 90) begin
        keep = $urandom_range(1, FRAME_LEN - 1);
        add_frame(8'($urandom), ftype, app, value, 8'h00, keep, calm);
        used += keep;
      end else begin
        repeat ($urandom_range(1, 4))
          push_byte(8'($urandom), calm);
      end
      n++;
    end
  endtask

  // block is idle: nothing queued, nothing offered, no result outstanding
  task automatic settle();
    do @(negedge clk_i);
    while (byte_backlog.size() != 0 || in_valid_i || expected_frames.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  // write, then read the drop register back
  task automatic cfg_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (addr[AddrW-1:2] == REG_DROP_BAD)
      drop_bad_shadow = data[0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= DROP_BAD_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    if (prdata[0] !== drop_bad_shadow)
      note_mismatch("drop_bad_frames read-back", 32'(drop_bad_shadow), 32'(prdata[0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : test_sequence
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: bytes before any start byte are ignored
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    // partial frame cut by a new start byte
    push_byte(START_BYTE, 1'b1);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    // good frame whose checksum byte is itself a start byte: restarts instead
    add_frame(8'h5A, 8'h81, 16'h0000, 32'h0, 8'h00, FRAME_LEN, 1'b1);
    // field extremes, known id
    add_frame(8'hFF, 8'h00, 16'hF104, 32'hFFFF_FFFF, 8'h00, FRAME_LEN, 1'b0);

    // default setting: bad frames dropped
    add_random(180);
    settle();

    // unmapped slot must not touch the register, then let bad frames through
    cfg_write(UNMAPPED_ADDR, 32'h0);
    cfg_write(DROP_BAD_ADDR, {31'($urandom), 1'b0});
    add_random(250);
    settle();

    cfg_write(DROP_BAD_ADDR, {31'($urandom), 1'b1});
    add_random(200);
    settle();

    if (mismatches == 0 && expected_frames.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin : watchdog
    #500_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: files.f
design/tfd_pkg.sv
design/telemetry_frame_deframer.sv
dv/testbench.sv
